// File: src/gbfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbfp_pkg
// Shared types, constants and the bytewise CRC-32 step for the GNSS binary
// frame parser.
// ----------------------------------------------------------------------------
package gbfp_pkg;

    // sync pattern and header limits
    localparam logic [7:0]  SYNC_A     = 8'hAA;
    localparam logic [7:0]  SYNC_B     = 8'h44;
    localparam logic [7:0]  SYNC_C     = 8'h12;
    localparam logic [7:0]  MIN_HEADER = 8'd10;

    // reflected CRC-32 polynomial
    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;

    // default frame size limit in bytes
    localparam int          FRAME_LIMIT_DEF = 8192;

    // header + payload + 4 fits in 17 bits
    localparam int          TOTAL_W    = 17;
    localparam int          OFFSET_W   = 13;

    // stream widths
    localparam int          S_TDATA_W  = 8;
    localparam int          M_TDATA_W  = 56;
    localparam int          M_TUSER_W  = 4;

    // register map
    localparam int          PADDR_W    = 3;
    localparam logic        REG_MAX_HDR = 1'b0;
    localparam logic        REG_MAX_PAY = 1'b1;
    localparam logic [7:0]  MAX_HDR_RST = 8'd28;
    localparam logic [15:0] MAX_PAY_RST = 16'd4096;

    typedef enum logic [2:0] {
        PH_SYNC1  = 3'd0,
        PH_SYNC2  = 3'd1,
        PH_SYNC3  = 3'd2,
        PH_HLEN   = 3'd3,
        PH_HEADER = 3'd4,
        PH_BODY   = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE = 3'd0,
        EV_OK   = 3'd1,
        EV_CRC  = 3'd2,
        EV_SYNC = 3'd3,
        EV_HLEN = 3'd4,
        EV_PLEN = 3'd5,
        EV_OVF  = 3'd6
    } ev_t;

    typedef struct packed {
        logic [7:0]  max_header_length;
        logic [15:0] max_payload_length;
    } cfg_t;

    typedef struct packed {
        logic [15:0]         payload_length;
        logic [15:0]         message_id;
        ev_t                 event_res;
        logic                in_frame;
        logic [OFFSET_W-1:0] frame_offset;
        logic [7:0]          echo_byte;
    } result_t;

    // one byte through the reflected CRC-32, one bit per step
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: src/gbfp_apb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbfp_apb_regs
// APB register file: max header length and max payload length.
// ----------------------------------------------------------------------------
module gbfp_apb_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gbfp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output gbfp_pkg::cfg_t               cfg
);

    logic [7:0]  max_hdr_reg;
    logic [15:0] max_pay_reg;
    logic        wr_en;
    logic        reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_hdr_reg <= gbfp_pkg::MAX_HDR_RST;
            max_pay_reg <= gbfp_pkg::MAX_PAY_RST;
        end
        else if (wr_en)
        begin
            if (reg_sel == gbfp_pkg::REG_MAX_HDR)
                max_hdr_reg <= pwdata[7:0];
            else
                max_pay_reg <= pwdata[15:0];
        end
    end

    always_comb
    begin
        case (reg_sel)
            gbfp_pkg::REG_MAX_HDR: prdata = {24'h0, max_hdr_reg};
            gbfp_pkg::REG_MAX_PAY: prdata = {16'h0, max_pay_reg};
            default:               prdata = 32'h0;
        endcase
    end

    assign cfg.max_header_length  = max_hdr_reg;
    assign cfg.max_payload_length = max_pay_reg;

endmodule

// File: src/gbfp_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbfp_in_reg
// Input register stage: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module gbfp_in_reg
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       take,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    // stage is free when empty or drained this cycle
    assign s_tready   = !valid_reg || take;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            data_reg <= s_tdata;
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

// File: src/gbfp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbfp_core
// Frame state machine, CRC-32 and result register. One byte per cycle while results are accepted.
// ----------------------------------------------------------------------------
module gbfp_core
#(
    parameter int FRAME_LIMIT = gbfp_pkg::FRAME_LIMIT_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  gbfp_pkg::cfg_t      cfg,
    input  logic                byte_valid,
    input  logic [7:0]          byte_data,
    output logic                take,
    output logic                res_valid,
    input  logic                res_ready,
    output gbfp_pkg::result_t   res
);

    localparam int CNT_W = $clog2(FRAME_LIMIT + 1);
    localparam int TW    = gbfp_pkg::TOTAL_W;
    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(FRAME_LIMIT);

    gbfp_pkg::phase_t    phase_reg, phase_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [7:0]          hdr_reg, hdr_next;
    logic [TW-1:0]       total_reg, total_next;
    logic [15:0]         id_reg, id_next;
    logic [15:0]         len_reg, len_next;
    logic [31:0]         crc_reg, crc_next;
    logic [31:0]         crcrx_reg, crcrx_next;

    logic                out_valid_reg;
    gbfp_pkg::result_t   res_reg, res_next;

    // shared conditions
    logic [CNT_W-1:0]    cnt_inc;
    logic [31:0]         crc_upd;
    logic [31:0]         cnt_wide;
    logic                ovf;
    logic                sync_hit;
    logic                hlen_bad;
    logic [15:0]         id_upd;
    logic [15:0]         len_upd;
    logic                hdr_done;
    logic                pay_bad;
    logic                in_body_data;
    logic [31:0]         crcrx_shift;
    logic [TW-1:0]       body_total;
    logic                frame_done;

    assign take     = byte_valid && (!out_valid_reg || res_ready);
    assign cnt_inc  = cnt_reg + 1'b1;
    assign crc_upd  = gbfp_pkg::crc_byte(crc_reg, byte_data);
    assign cnt_wide = 32'(cnt_reg);
    assign ovf      = (cnt_reg >= LIMIT);

    assign sync_hit = (phase_reg == gbfp_pkg::PH_SYNC2) ? (byte_data == gbfp_pkg::SYNC_B)
                                                        : (byte_data == gbfp_pkg::SYNC_C);
    assign hlen_bad = (byte_data < gbfp_pkg::MIN_HEADER) ||
                      (byte_data > cfg.max_header_length);

    // id at offsets 4-5, length at 8-9, little-endian
    always_comb
    begin
        id_upd  = id_reg;
        len_upd = len_reg;
        if (cnt_wide == 32'd4) id_upd[7:0]   = byte_data;
        if (cnt_wide == 32'd5) id_upd[15:8]  = byte_data;
        if (cnt_wide == 32'd8) len_upd[7:0]  = byte_data;
        if (cnt_wide == 32'd9) len_upd[15:8] = byte_data;
    end

    assign hdr_done     = (TW'(cnt_inc) >= TW'(hdr_reg));
    assign pay_bad      = (len_upd > cfg.max_payload_length);
    assign body_total   = TW'(hdr_reg) + TW'(len_reg);
    assign in_body_data = (TW'(cnt_reg) < body_total);
    assign crcrx_shift  = {byte_data, crcrx_reg[31:8]};
    assign frame_done   = (TW'(cnt_inc) >= total_reg);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            gbfp_pkg::PH_SYNC1:
                if (byte_data == gbfp_pkg::SYNC_A) phase_next = gbfp_pkg::PH_SYNC2;
            gbfp_pkg::PH_SYNC2:
                phase_next = sync_hit ? gbfp_pkg::PH_SYNC3 : gbfp_pkg::PH_SYNC1;
            gbfp_pkg::PH_SYNC3:
                phase_next = sync_hit ? gbfp_pkg::PH_HLEN : gbfp_pkg::PH_SYNC1;
            gbfp_pkg::PH_HLEN:
                phase_next = hlen_bad ? gbfp_pkg::PH_SYNC1 : gbfp_pkg::PH_HEADER;
            gbfp_pkg::PH_HEADER:
                if (ovf || (hdr_done && pay_bad))
                    phase_next = gbfp_pkg::PH_SYNC1;
                else if (hdr_done)
                    phase_next = gbfp_pkg::PH_BODY;
            gbfp_pkg::PH_BODY:
                if (ovf || frame_done) phase_next = gbfp_pkg::PH_SYNC1;
            default:
                phase_next = gbfp_pkg::PH_SYNC1;
        endcase
    end

    // datapath and result
    always_comb
    begin
        cnt_next   = cnt_reg;
        hdr_next   = hdr_reg;
        total_next = total_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        crc_next   = crc_reg;
        crcrx_next = crcrx_reg;

        res_next.echo_byte      = byte_data;
        res_next.frame_offset   = cnt_wide[gbfp_pkg::OFFSET_W-1:0];
        res_next.in_frame       = 1'b0;
        res_next.event_res      = gbfp_pkg::EV_NONE;
        res_next.message_id     = 16'h0;
        res_next.payload_length = 16'h0;

        case (phase_reg)
            gbfp_pkg::PH_SYNC1:
            begin
                res_next.frame_offset = '0;
                if (byte_data == gbfp_pkg::SYNC_A)
                begin
                    crc_next          = gbfp_pkg::crc_byte(32'h0, byte_data);
                    cnt_next          = CNT_W'(1);
                    res_next.in_frame = 1'b1;
                end
            end
            gbfp_pkg::PH_SYNC2, gbfp_pkg::PH_SYNC3:
            begin
                if (sync_hit)
                begin
                    crc_next          = crc_upd;
                    cnt_next          = cnt_inc;
                    res_next.in_frame = 1'b1;
                end
                else
                begin
                    res_next.event_res = gbfp_pkg::EV_SYNC;
                    cnt_next           = '0;
                end
            end
            gbfp_pkg::PH_HLEN:
            begin
                if (hlen_bad)
                begin
                    res_next.event_res = gbfp_pkg::EV_HLEN;
                    cnt_next           = '0;
                end
                else
                begin
                    hdr_next          = byte_data;
                    crc_next          = crc_upd;
                    cnt_next          = cnt_inc;
                    res_next.in_frame = 1'b1;
                end
            end
            gbfp_pkg::PH_HEADER:
            begin
                if (ovf)
                begin
                    res_next.event_res = gbfp_pkg::EV_OVF;
                    cnt_next           = '0;
                end
                else
                begin
                    id_next           = id_upd;
                    len_next          = len_upd;
                    crc_next          = crc_upd;
                    cnt_next          = cnt_inc;
                    res_next.in_frame = 1'b1;
                    if (hdr_done)
                    begin
                        if (pay_bad)
                        begin
                            res_next.event_res = gbfp_pkg::EV_PLEN;
                            cnt_next           = '0;
                        end
                        else
                        begin
                            total_next = TW'(hdr_reg) + TW'(len_upd) + TW'(4);
                            crcrx_next = 32'h0;
                        end
                    end
                end
            end
            gbfp_pkg::PH_BODY:
            begin
                if (ovf)
                begin
                    res_next.event_res = gbfp_pkg::EV_OVF;
                    cnt_next           = '0;
                end
                else
                begin
                    res_next.in_frame = 1'b1;
                    cnt_next          = cnt_inc;
                    if (in_body_data)
                        crc_next   = crc_upd;
                    else
                        crcrx_next = crcrx_shift;
                    if (frame_done)
                    begin
                        res_next.event_res      = (crcrx_next == crc_next) ? gbfp_pkg::EV_OK
                                                                           : gbfp_pkg::EV_CRC;
                        res_next.message_id     = id_reg;
                        res_next.payload_length = len_reg;
                        cnt_next                = '0;
                    end
                end
            end
            default:
            begin
                res_next.frame_offset = '0;
                cnt_next              = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= gbfp_pkg::PH_SYNC1;
            cnt_reg       <= '0;
            hdr_reg       <= '0;
            total_reg     <= '0;
            id_reg        <= '0;
            len_reg       <= '0;
            crc_reg       <= '0;
            crcrx_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                hdr_reg   <= hdr_next;
                total_reg <= total_next;
                id_reg    <= id_next;
                len_reg   <= len_next;
                crc_reg   <= crc_next;
                crcrx_reg <= crcrx_next;
            end
            if (take)
                out_valid_reg <= 1'b1;
            else if (res_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            res_reg <= res_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

// File: src/gnss_binary_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnss_binary_frame_parser
// Byte-serial framer for GNSS binary logs with CRC-32 check.
// ----------------------------------------------------------------------------
// Takes one receiver byte per transaction and returns exactly one result per
// byte. The result register is loaded at the same edge that takes the byte out
// of the input register, so a steady stream runs at one byte per clock while
// m_tready stays high. Each byte passes the input register, then the result
// register. The rate is set by the single state machine and bytewise CRC-32
// step that sit between the input register and the result register; a result
// that waits stalls the input register and, once it is full, the input side.
// Framing: sync AA 44 12, header length byte (10..max_header_length), rest of
// header (message id at offsets 4-5, payload length at 8-9, little-endian),
// payload, then a 4-byte little-endian CRC-32 (reflected 0xEDB88320, init 0,
// no final xor) over header plus payload. Each byte is echoed with its frame
// offset, an in-frame flag and an event code; the last CRC byte carries
// frame ok or crc error together with message id and payload length.
// ----------------------------------------------------------------------------
module gnss_binary_frame_parser
#(
    parameter int FRAME_LIMIT = gbfp_pkg::FRAME_LIMIT_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,

    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [gbfp_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] data_byte

    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] echo_byte, [20:8] frame_offset, [36:21] message_id,
    // [52:37] payload_length, [55:53] zero
    output logic [gbfp_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] in_frame, [3:1] event_res
    output logic [gbfp_pkg::M_TUSER_W-1:0] m_tuser,

    // configuration: 0x0 max_header_length, 0x4 max_payload_length
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gbfp_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    gbfp_pkg::cfg_t    cfg;
    gbfp_pkg::result_t res;
    logic              byte_valid;
    logic [7:0]        byte_data;
    logic              take;

    gbfp_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register stage
    gbfp_in_reg u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (take),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    // parser state machine, CRC and result register
    gbfp_core #(.FRAME_LIMIT(FRAME_LIMIT)) u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .take       (take),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tdata = {3'b000, res.payload_length, res.message_id,
                      res.frame_offset, res.echo_byte};
    assign m_tuser = {res.event_res, res.in_frame};

    // bytes rejected for sync, header length or overflow are never part of a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[3:1] == gbfp_pkg::EV_SYNC ||
                      m_tuser[3:1] == gbfp_pkg::EV_HLEN ||
                      m_tuser[3:1] == gbfp_pkg::EV_OVF)) |-> !m_tuser[0])
        else $error("rejected byte flagged in_frame");

    // id and length only reported at frame end
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !(m_tuser[3:1] == gbfp_pkg::EV_OK ||
                       m_tuser[3:1] == gbfp_pkg::EV_CRC))
        |-> (m_tdata[52:21] == 32'h0))
        else $error("message id or length outside frame end");

    // stray bytes while hunting carry offset zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0] && m_tuser[3:1] == gbfp_pkg::EV_NONE)
        |-> (m_tdata[20:8] == 13'h0))
        else $error("stray byte with nonzero offset");

    // a frame end or payload length error is always a frame byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[3:1] == gbfp_pkg::EV_OK ||
                      m_tuser[3:1] == gbfp_pkg::EV_CRC ||
                      m_tuser[3:1] == gbfp_pkg::EV_PLEN)) |-> m_tuser[0])
        else $error("frame event on byte outside frame");

endmodule
